FILE: src/palette_color_matcher_defines.svh
// Assertion macros shared by the palette color matcher checkers.
`ifndef PALETTE_COLOR_MATCHER_DEFINES_SVH
`define PALETTE_COLOR_MATCHER_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define PCM_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// An expression that must never be true.
`define PCM_ASSERT_NEVER(label, expr, msg) \
	`PCM_ASSERT_CLK(label, !(expr), msg)

`endif

FILE: src/pcm_pkg.sv
// Package with the types, codes and constants of the palette color matcher.
package pcm_pkg;

	// Default palette depth.
	localparam int ENTRIES_DEF = 256;
	// Largest number of entries a query ever scans.
	localparam int SEARCH_MAX = 256;

	localparam int CHAN_W = 8;
	localparam int COLOR_W = 3 * CHAN_W;
	localparam int SQ_W = 2 * CHAN_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int CFG_W = 9;
	localparam int DIST_W = 21;

	localparam logic [CFG_W-1:0] NUM_COLORS_RST = 9'd256;
	localparam logic [DIST_W-1:0] DIST_START = 21'h100000;

	// Item operation codes.
	typedef enum logic [1:0] {
		FUNC_WR_COLOR = 2'd0,
		FUNC_WR_USED  = 2'd1,
		FUNC_NEAREST  = 2'd2,
		FUNC_EXACT    = 2'd3
	} func_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_color;
		logic wr_used;
		logic start;
		logic issue;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic at_last;
		logic busy;
	} status_t;

endpackage

FILE: src/pcm_in_if.sv
// Input channel interface: one item per transaction.
interface pcm_in_if;
	import pcm_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic [CHAN_W-1:0] entry_index;
	logic [CHAN_W-1:0] red_value;
	logic [CHAN_W-1:0] green_value;
	logic [CHAN_W-1:0] blue_value;
	logic              used_mark;

	modport source (
		output valid, func, entry_index, red_value, green_value, blue_value, used_mark,
		input  ready
	);
	modport sink (
		input  valid, func, entry_index, red_value, green_value, blue_value, used_mark,
		output ready
	);
endinterface

FILE: src/pcm_out_if.sv
// Result channel interface: one query answer per transaction.
interface pcm_out_if;
	import pcm_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] match_index;
	logic              match_found;

	modport source (
		output valid, match_index, match_found,
		input  ready
	);
	modport sink (
		input  valid, match_index, match_found,
		output ready
	);
endinterface

FILE: src/palette_color_matcher.sv
// Top level of the palette color matcher: nearest and exact color search over a palette.
//
// in_ch carries one item per transaction: a color write, a used flag write,
// a nearest-color query or an exact-color query. Writes give no result; each
// query gives exactly one transaction on out_ch with match_index and
// match_found. cfg_wr_en with cfg_wr_data sets num_colors, the number of
// entries searched; write it only while no query is in flight.
// A write is stored as it is taken. A query scans n entries, n being the
// search count (at most 256): the color and used memories give one entry
// per cycle through a single read port, followed by a two-stage distance
// pipeline, before the result is shown. One item is handled at a
// time: in_ch.ready is high only while the block is idle.
// Reset clears the used flags and sets num_colors to 256; palette colors are
// undefined until written. When the receiver stalls, the result is held in
// its registers on out_ch and no new item is taken until it is accepted.
module palette_color_matcher #(
	parameter int ENTRIES = pcm_pkg::ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	pcm_in_if.sink                    in_ch,
	pcm_out_if.source                 out_ch,
	input  logic                      cfg_wr_en,
	input  logic [pcm_pkg::CFG_W-1:0] cfg_wr_data
);
	import pcm_pkg::*;

	cmd_t    cmd;
	status_t status;
	func_t   in_func;

	assign in_func = func_t'(in_ch.func);

	// Sequencer.
	pcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.in_func  (in_func),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.cmd      (cmd),
		.status   (status)
	);

	// Palette storage and search.
	pcm_datapath #(
		.ENTRIES(ENTRIES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.func       (in_func),
		.entry_index(in_ch.entry_index),
		.red_value  (in_ch.red_value),
		.green_value(in_ch.green_value),
		.blue_value (in_ch.blue_value),
		.used_mark  (in_ch.used_mark),
		.match_index(out_ch.match_index),
		.match_found(out_ch.match_found)
	);
endmodule

FILE: src/pcm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pcm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

FILE: src/pcm_ctrl.sv
// Controller state machine: takes items, sequences the scan and hands out results.
module pcm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pcm_pkg::func_t   in_func,
	output logic             out_valid,
	input  logic             out_ready,
	output pcm_pkg::cmd_t    cmd,
	input  pcm_pkg::status_t status
);
	import pcm_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   in_take;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		in_take   = in_valid;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_take) begin
					unique case (in_func) inside
						FUNC_WR_COLOR: cmd.wr_color = 1'b1;
						FUNC_WR_USED:  cmd.wr_used = 1'b1;
						FUNC_NEAREST, FUNC_EXACT: begin
							cmd.start = 1'b1;
							state_d   = ST_SCAN;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (status.at_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.busy) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

FILE: src/pcm_datapath.sv
// Datapath: palette memories, scan counter, distance pipeline and best-match registers.
module pcm_datapath #(
	parameter int ENTRIES = pcm_pkg::ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pcm_pkg::cmd_t              cmd,
	output pcm_pkg::status_t           status,
	input  logic                       cfg_wr_en,
	input  logic [pcm_pkg::CFG_W-1:0]  cfg_wr_data,
	input  pcm_pkg::func_t             func,
	input  logic [pcm_pkg::CHAN_W-1:0] entry_index,
	input  logic [pcm_pkg::CHAN_W-1:0] red_value,
	input  logic [pcm_pkg::CHAN_W-1:0] green_value,
	input  logic [pcm_pkg::CHAN_W-1:0] blue_value,
	input  logic                       used_mark,
	output logic [pcm_pkg::CHAN_W-1:0] match_index,
	output logic                       match_found
);
	import pcm_pkg::*;

	// Entries that can be addressed and searched.
	localparam int LIM = (ENTRIES < SEARCH_MAX) ? ENTRIES : SEARCH_MAX;
	localparam int CW = $clog2(LIM);
	localparam logic [CFG_W-1:0] LIM_C = CFG_W'(LIM);

	function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

	logic [CFG_W-1:0]   num_colors_q;
	logic [CFG_W-1:0]   n_clamp;
	logic [CW-1:0]      last_q;
	logic [CW-1:0]      cnt_q;
	logic               wr_ok;
	logic [CW-1:0]      wr_addr;
	logic [LIM-1:0]     used_vld_q;
	logic [COLOR_W-1:0] want_q;
	logic               near_q;
	logic               found_q;
	logic [CW-1:0]      best_idx_q;
	logic [DIST_W-1:0]  best_d_q;

	logic               vld_s1;
	logic [CW-1:0]      idx_s1;
	logic               uvld_s1;
	logic [COLOR_W-1:0] color_s1;
	logic               used_s1;

	logic               vld_s2;
	logic [CW-1:0]      idx_s2;
	logic [SQ_W-1:0]    sq_r_s2;
	logic [SQ_W-1:0]    sq_g_s2;
	logic [SQ_W-1:0]    sq_b_s2;
	logic               hit_s2;

	logic [CHAN_W-1:0]  dr;
	logic [CHAN_W-1:0]  dg;
	logic [CHAN_W-1:0]  db;
	logic [SUM_W-1:0]   dist_sum;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_colors_q <= NUM_COLORS_RST;
		end else if (cfg_wr_en) begin
			num_colors_q <= cfg_wr_data;
		end
	end

	// Search count: zero counts as one, large values saturate at the table size.
	always_comb begin
		if (num_colors_q == '0) begin
			n_clamp = CFG_W'(1);
		end else if (num_colors_q > LIM_C) begin
			n_clamp = LIM_C;
		end else begin
			n_clamp = num_colors_q;
		end
	end

	// Writes beyond the table are dropped.
	assign wr_ok   = ({1'b0, entry_index} < LIM_C);
	assign wr_addr = CW'(entry_index);

	// Color memory.
	pcm_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(LIM)
	) u_color_ram (
		.clk    (clk),
		.wr_en  (cmd.wr_color && wr_ok),
		.wr_addr(wr_addr),
		.wr_data({red_value, green_value, blue_value}),
		.rd_en  (cmd.issue),
		.rd_addr(cnt_q),
		.rd_data(color_s1)
	);

	// Used flag memory; an entry whose flag was never written reads as unused.
	pcm_ram #(
		.WIDTH(1),
		.DEPTH(LIM)
	) u_used_ram (
		.clk    (clk),
		.wr_en  (cmd.wr_used && wr_ok),
		.wr_addr(wr_addr),
		.wr_data(used_mark),
		.rd_en  (cmd.issue),
		.rd_addr(cnt_q),
		.rd_data(used_s1)
	);

	// Per-entry written marks for the used flags, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_vld_q <= '0;
		end else if (cmd.wr_used && wr_ok) begin
			used_vld_q[wr_addr] <= 1'b1;
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	// Query setup and scan address counter.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			want_q <= {red_value, green_value, blue_value};
			near_q <= (func == FUNC_NEAREST);
			last_q <= CW'(n_clamp - CFG_W'(1));
			cnt_q  <= '0;
		end else if (cmd.issue) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// Stage 1 side data next to the registered memory read.
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			idx_s1  <= cnt_q;
			uvld_s1 <= used_vld_q[cnt_q];
		end
	end

	// Stage 2: per-channel squared differences and the exact compare.
	assign dr = abs_diff(want_q[COLOR_W-1 -: CHAN_W], color_s1[COLOR_W-1 -: CHAN_W]);
	assign dg = abs_diff(want_q[2*CHAN_W-1 -: CHAN_W], color_s1[2*CHAN_W-1 -: CHAN_W]);
	assign db = abs_diff(want_q[CHAN_W-1:0], color_s1[CHAN_W-1:0]);

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			idx_s2  <= idx_s1;
			sq_r_s2 <= SQ_W'(dr) * SQ_W'(dr);
			sq_g_s2 <= SQ_W'(dg) * SQ_W'(dg);
			sq_b_s2 <= SQ_W'(db) * SQ_W'(db);
			hit_s2  <= uvld_s1 && used_s1 && (color_s1 == want_q);
		end
	end

	// Stage 3: distance sum and best-match update; lower index wins ties.
	assign dist_sum = SUM_W'(sq_r_s2) + SUM_W'(sq_g_s2) + SUM_W'(sq_b_s2);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			found_q    <= (func == FUNC_NEAREST);
			best_idx_q <= '0;
			best_d_q   <= DIST_START;
		end else if (vld_s2) begin
			if (near_q) begin
				if (DIST_W'(dist_sum) < best_d_q) begin
					best_d_q   <= DIST_W'(dist_sum);
					best_idx_q <= idx_s2;
				end
			end else if (hit_s2 && !found_q) begin
				found_q    <= 1'b1;
				best_idx_q <= idx_s2;
			end
		end
	end

	// Status and result.
	assign status.at_last = (cnt_q == last_q);
	assign status.busy    = vld_s1 || vld_s2;
	assign match_index    = CHAN_W'(best_idx_q);
	assign match_found    = found_q;
endmodule

FILE: src/pcm_checker.sv
// Port-level checker for the palette color matcher and its bind statement.
`include "palette_color_matcher_defines.svh"

module pcm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] in_func,
	input logic       out_valid,
	input logic       out_ready
);
	import pcm_pkg::*;

	logic in_take;
	logic query_take;

	assign in_take    = in_valid && in_ready;
	assign query_take = in_take && (in_func == FUNC_NEAREST || in_func == FUNC_EXACT);

	// A result stays offered until the receiver takes it.
	`PCM_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
	// One item at a time: no new item while a result is offered.
	`PCM_ASSERT_NEVER(a_ready_vs_result, in_ready && out_valid, "item taken while result pending")
	// After a query transaction the input stays closed and no result appears at once.
	`PCM_ASSERT_CLK(a_query_busy, query_take |=> !in_ready && !out_valid, "query did not start a scan")
	// A write transaction gives no result and leaves the block ready.
	`PCM_ASSERT_CLK(a_write_quiet, in_take && !query_take |=> in_ready && !out_valid, "write gave a result")
endmodule

bind palette_color_matcher pcm_checker u_pcm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.in_func  (in_ch.func),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready)
);

FILE: bench/pcm_match_checker.sv
// Checker that predicts palette search answers and compares them with the result channel.
`timescale 1ns / 100ps

module pcm_match_checker #(
	parameter int ENTRIES = pcm_pkg::ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	pcm_in_if                         in_mon,
	pcm_out_if                        out_mon,
	input  logic                      cfg_wr_en,
	input  logic [pcm_pkg::CFG_W-1:0] cfg_wr_data,
	output int                        fail_count,
	output int                        pending
);
	import pcm_pkg::*;

	// One predicted answer of a query.
	typedef struct packed {
		logic [CHAN_W-1:0] index;
		logic              found;
	} match_t;

	// Private copy of the palette, the used flags and the search count.
	logic [COLOR_W-1:0] palette_colors [ENTRIES];
	logic               palette_used [ENTRIES];
	logic [CFG_W-1:0]   search_len;

	match_t expected_matches [$];

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		fail_count++;
	endtask

	function automatic int sq_gap(input int a, input int b);
		int d;
		d = a - b;
		return d * d;
	endfunction

	// Works out the answer of a nearest or exact query over the current palette.
	function automatic match_t predict_match(input func_t f, input logic [COLOR_W-1:0] want);
		match_t ans;
		int span;
		int lim;
		int best_d;
		int d;
		logic [COLOR_W-1:0] c;
		lim = (ENTRIES < SEARCH_MAX) ? ENTRIES : SEARCH_MAX;
		span = (search_len == '0) ? 1 : int'(search_len);
		if (span > lim) begin
			span = lim;
		end
		ans = '0;
		if (f == FUNC_NEAREST) begin
			// Strict less-than keeps the lowest index on ties.
			best_d = int'(DIST_START);
			ans.found = 1'b1;
			for (int i = 0; i < span; i++) begin
				c = palette_colors[i];
				d = sq_gap(want[23:16], c[23:16]) + sq_gap(want[15:8], c[15:8])
					+ sq_gap(want[7:0], c[7:0]);
				if (d < best_d) begin
					best_d = d;
					ans.index = CHAN_W'(i);
				end
			end
		end else begin
			// First used entry with the same color wins; none leaves index 0, not found.
			for (int i = 0; i < span; i++) begin
				if (palette_used[i] && palette_colors[i] == want) begin
					ans.index = CHAN_W'(i);
					ans.found = 1'b1;
					break;
				end
			end
		end
		return ans;
	endfunction

	// Track every transaction on both channels and every register write.
	always @(posedge clk or negedge arst_n) begin
		match_t exp_m;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				palette_colors[i] = '0;
				palette_used[i] = 1'b0;
			end
			search_len = NUM_COLORS_RST;
			expected_matches.delete();
			pending <= 0;
		end else begin
			// Result transactions are checked against the oldest expectation.
			if (out_mon.valid && out_mon.ready) begin
				if (expected_matches.size() == 0) begin
					report_mismatch($sformatf("result index %0d found %0b with no query waiting",
						out_mon.match_index, out_mon.match_found));
				end else begin
					exp_m = expected_matches.pop_front();
					if (out_mon.match_index !== exp_m.index) begin
						report_mismatch($sformatf("match_index got %0d expected %0d",
							out_mon.match_index, exp_m.index));
					end
					if (out_mon.match_found !== exp_m.found) begin
						report_mismatch($sformatf("match_found got %0b expected %0b",
							out_mon.match_found, exp_m.found));
					end
				end
			end
			if (cfg_wr_en) begin
				search_len = cfg_wr_data;
			end
			// Input transactions update the palette or queue a predicted answer.
			if (in_mon.valid && in_mon.ready) begin
				case (func_t'(in_mon.func))
					FUNC_WR_COLOR: begin
						if (int'(in_mon.entry_index) < ENTRIES) begin
							palette_colors[in_mon.entry_index] =
								{in_mon.red_value, in_mon.green_value, in_mon.blue_value};
						end
					end
					FUNC_WR_USED: begin
						if (int'(in_mon.entry_index) < ENTRIES) begin
							palette_used[in_mon.entry_index] = in_mon.used_mark;
						end
					end
					default: begin
						expected_matches.push_back(predict_match(func_t'(in_mon.func),
							{in_mon.red_value, in_mon.green_value, in_mon.blue_value}));
					end
				endcase
			end
			pending <= expected_matches.size();
		end
	end

endmodule

FILE: bench/tb.sv
// Top of the palette color matcher testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
	import pcm_pkg::*;

	localparam int LIMIT_CYCLES = 2000000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 300;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 45;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;
	int               fail_count;
	int               match_pending;
	int               cycle_count = 0;

	// Idle rates in percent, changed between phases.
	int send_idle_pct = 35;
	int recv_idle_pct = 85;

	// Long receiver hold-off: the stimulus raises hold_asks, the receiver answers it.
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// Colors written so far and the effective search span, used to aim queries.
	logic [COLOR_W-1:0] color_shadow [SEARCH_MAX];
	int                 search_span = SEARCH_MAX;

	pcm_in_if  in_bus ();
	pcm_out_if out_bus ();

	palette_color_matcher #(
		.ENTRIES(ENTRIES_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_bus),
		.out_ch(out_bus),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	pcm_match_checker #(
		.ENTRIES(ENTRIES_DEF)
	) match_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_mon(in_bus),
		.out_mon(out_bus),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.fail_count(fail_count),
		.pending(match_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Give up on a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: random stalls, plus the long hold-off when one is asked for.
	initial begin
		out_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_bus.ready <= 1'b0;
			end else if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
				out_bus.ready <= 1'b0;
			end else begin
				out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Offers one item after a random gap and waits for its transaction.
	task automatic send_item(input func_t f, input logic [7:0] idx,
			input logic [COLOR_W-1:0] rgb, input logic mark);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_bus.valid <= 1'b0;
			in_bus.func <= 2'($urandom);
			in_bus.entry_index <= 8'($urandom);
			in_bus.red_value <= 8'($urandom);
			in_bus.green_value <= 8'($urandom);
			in_bus.blue_value <= 8'($urandom);
			in_bus.used_mark <= 1'($urandom);
			@(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.func <= f;
		in_bus.entry_index <= idx;
		in_bus.red_value <= rgb[23:16];
		in_bus.green_value <= rgb[15:8];
		in_bus.blue_value <= rgb[7:0];
		in_bus.used_mark <= mark;
		if (f == FUNC_WR_COLOR) begin
			color_shadow[idx] = rgb;
		end
		do @(posedge clk); while (!in_bus.ready);
	endtask

	// Stops offering items until every answer has come and the block is idle.
	task automatic wait_drained();
		in_bus.valid <= 1'b0;
		do @(posedge clk); while (match_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes num_colors while the block is idle.
	task automatic set_search_len(input logic [CFG_W-1:0] v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		search_span = (v == '0) ? 1 : ((v > CFG_W'(SEARCH_MAX)) ? SEARCH_MAX : int'(v));
	endtask

	// One random item, aimed mostly at entries inside the search span.
	task automatic random_item();
		int pick;
		logic [7:0] idx;
		logic [COLOR_W-1:0] rgb;
		logic [COLOR_W-1:0] base;
		int ch;
		pick = $urandom_range(0, 99);
		idx = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, search_span - 1)) : 8'($urandom);
		base = color_shadow[$urandom_range(0, search_span - 1)];
		rgb = 24'($urandom);
		if (pick < 30) begin
			// Copies of existing colors make ties and several exact hits.
			if ($urandom_range(0, 99) < 15) begin
				rgb = base;
			end
			send_item(FUNC_WR_COLOR, idx, rgb, 1'($urandom));
		end else if (pick < 50) begin
			send_item(FUNC_WR_USED, idx, rgb, 1'($urandom));
		end else if (pick < 75) begin
			// Half of the nearest queries sit close to a stored color.
			if ($urandom_range(0, 1) == 1) begin
				for (int k = 0; k < 3; k++) begin
					ch = int'(base[k*8 +: 8]) + $urandom_range(0, 6) - 3;
					ch = (ch < 0) ? 0 : ((ch > 255) ? 255 : ch);
					rgb[k*8 +: 8] = 8'(ch);
				end
			end
			send_item(FUNC_NEAREST, 8'($urandom), rgb, 1'($urandom));
		end else begin
			if ($urandom_range(0, 99) < 65) begin
				rgb = base;
			end
			send_item(FUNC_EXACT, 8'($urandom), rgb, 1'($urandom));
		end
	endtask

	// Stimulus: preload, directed cases, random phases, then the verdict.
	initial begin
		logic [COLOR_W-1:0] c;
		logic [CFG_W-1:0] setting;
		arst_n = 1'b0;
		in_bus.valid <= 1'b0;
		in_bus.func <= FUNC_WR_COLOR;
		in_bus.entry_index <= '0;
		in_bus.red_value <= '0;
		in_bus.green_value <= '0;
		in_bus.blue_value <= '0;
		in_bus.used_mark <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every color is written before any query reads it.
		for (int i = 0; i < SEARCH_MAX; i++) begin
			case (i)
				0:       c = 24'h000000;
				10, 20:  c = 24'h123456;
				255:     c = 24'hFFFFFF;
				default: c = 24'($urandom);
			endcase
			send_item(FUNC_WR_COLOR, 8'(i), c, 1'b0);
		end

		// Extremes of the color space with the full reset search count.
		send_item(FUNC_NEAREST, 8'hFF, 24'h000000, 1'b1);
		send_item(FUNC_NEAREST, 8'h00, 24'hFFFFFF, 1'b0);
		// Exact query before any entry is marked used finds nothing.
		send_item(FUNC_EXACT, 8'h00, 24'hFFFFFF, 1'b0);
		send_item(FUNC_WR_USED, 8'hFF, 24'($urandom), 1'b1);
		send_item(FUNC_EXACT, 8'hFF, 24'hFFFFFF, 1'b1);
		// Duplicate colors: the lowest used index wins.
		send_item(FUNC_WR_USED, 8'd10, 24'($urandom), 1'b1);
		send_item(FUNC_WR_USED, 8'd20, 24'($urandom), 1'b1);
		send_item(FUNC_EXACT, 8'h00, 24'h123456, 1'b0);
		send_item(FUNC_NEAREST, 8'h00, 24'h123456, 1'b0);
		send_item(FUNC_WR_USED, 8'd10, 24'($urandom), 1'b0);
		send_item(FUNC_EXACT, 8'h00, 24'h123456, 1'b0);
		send_item(FUNC_WR_COLOR, 8'd5, 24'h123456, 1'b0);
		send_item(FUNC_WR_USED, 8'd5, 24'($urandom), 1'b1);
		send_item(FUNC_EXACT, 8'h00, 24'h123456, 1'b1);
		send_item(FUNC_WR_USED, 8'd0, 24'($urandom), 1'b1);

		// Smallest search count: only entry 0 is seen.
		set_search_len(9'd1);
		send_item(FUNC_NEAREST, 8'h00, 24'hFFFFFF, 1'b0);
		send_item(FUNC_EXACT, 8'h00, 24'h000000, 1'b0);
		send_item(FUNC_EXACT, 8'h00, 24'hFFFFFF, 1'b0);
		// A write beyond the search count is still stored.
		send_item(FUNC_WR_COLOR, 8'd200, 24'hABCDEF, 1'b0);

		// A count of zero behaves as one.
		set_search_len(9'd0);
		send_item(FUNC_NEAREST, 8'h00, 24'h808080, 1'b0);
		send_item(FUNC_EXACT, 8'h00, 24'h000000, 1'b0);

		// The largest count saturates to the full palette.
		set_search_len(9'd511);
		send_item(FUNC_NEAREST, 8'h00, 24'hFFFFFF, 1'b0);
		send_item(FUNC_WR_USED, 8'd200, 24'($urandom), 1'b1);
		send_item(FUNC_EXACT, 8'h00, 24'hABCDEF, 1'b0);
		send_item(FUNC_NEAREST, 8'h00, 24'hABCDEF, 1'b0);

		// Random phases with different search counts and idle patterns.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       setting = CFG_W'($urandom_range(2, 48));
				1:       setting = 9'd256;
				2:       setting = 9'd0;
				3:       setting = CFG_W'($urandom_range(2, 64));
				4:       setting = CFG_W'($urandom_range(257, 511));
				default: setting = CFG_W'($urandom_range(1, 32));
			endcase
			set_search_len(setting);
			if (phase < 2) begin
				send_idle_pct = 35;
				recv_idle_pct = 85;
			end else if (phase < 4) begin
				send_idle_pct = 85;
				recv_idle_pct = 35;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// The receiver holds off while items keep coming, then the sender pauses.
				if (phase == 3 && k == 15) begin
					hold_asks++;
				end
				if (phase == 3 && k == 30) begin
					wait_drained();
				end
				random_item();
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
